// File: hdl/i2cm_pkg.sv
// Shared types for the I2C register transfer master: command codes and
// the packed transaction payloads of the item and result channels.
// No dependencies.
package i2cm_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_SUPPLY = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_byte;
    logic       busy_res;
    logic       nack_flag;
    logic       done_res;
  } result_t;

  localparam int unsigned BYTE_BITS = 8;

endpackage

// File: hdl/i2cm_core.sv
// Bus sequencer of the I2C master: transfer state, line levels and the
// one-phase step for each command. Depends on i2cm_pkg.
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  item_t   item,
  output result_t result
);

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_START     = 4'd1,
    ST_TX_ADDR   = 4'd2,
    ST_ACK_ADDR  = 4'd3,
    ST_TX_REG    = 4'd4,
    ST_ACK_REG   = 4'd5,
    ST_RESTART   = 4'd6,
    ST_TX_RADDR  = 4'd7,
    ST_ACK_RADDR = 4'd8,
    ST_WAIT_DATA = 4'd9,
    ST_TX_DATA   = 4'd10,
    ST_ACK_DATA  = 4'd11,
    ST_RX        = 4'd12,
    ST_MACK      = 4'd13,
    ST_STOP      = 4'd14
  } state_t;

  state_t     state, state_next;
  logic [1:0] line_phase, line_phase_next;
  logic [3:0] bit_counter, bit_counter_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] saved_slave, saved_slave_next;
  logic [7:0] saved_register, saved_register_next;
  logic       read_mode, read_mode_next;
  logic       held_scl, held_scl_next;
  logic       held_sda, held_sda_next;
  logic       nack_latch, nack_latch_next;

  logic [3:0] bc_inc;
  logic [7:0] rx_shift;
  logic       tx_bit;
  logic       mack_bit;
  logic       rv;
  logic [7:0] rb;
  logic       dn;

  assign bc_inc   = bit_counter + 4'd1;
  assign rx_shift = {shift_byte[BYTE_BITS-2:0], item.sda_in};
  assign tx_bit   = shift_byte[BYTE_BITS-1];
  assign mack_bit = (bytes_left == 8'd0);

  always_comb begin
    state_next          = state;
    line_phase_next     = line_phase;
    bit_counter_next    = bit_counter;
    shift_byte_next     = shift_byte;
    bytes_left_next     = bytes_left;
    saved_slave_next    = saved_slave;
    saved_register_next = saved_register;
    read_mode_next      = read_mode;
    held_scl_next       = held_scl;
    held_sda_next       = held_sda;
    nack_latch_next     = nack_latch;
    rv                  = 1'b0;
    rb                  = 8'd0;
    dn                  = 1'b0;

    unique case (item.func)
      FUNC_TICK: begin
        unique case (state)
          ST_START, ST_RESTART: begin
            unique case (line_phase)
              2'd0: begin held_scl_next = 1'b0; held_sda_next = 1'b1; end
              2'd1: begin held_scl_next = 1'b1; held_sda_next = 1'b1; end
              2'd2: begin held_scl_next = 1'b1; held_sda_next = 1'b0; end
              default: begin held_scl_next = 1'b0; held_sda_next = 1'b0; end
            endcase
            if (line_phase != 2'd3) begin
              line_phase_next = line_phase + 2'd1;
            end else begin
              line_phase_next  = 2'd0;
              bit_counter_next = 4'd0;
              if (state == ST_START) begin
                shift_byte_next = saved_slave;
                state_next      = ST_TX_ADDR;
              end else begin
                shift_byte_next = saved_slave + 8'd1;
                state_next      = ST_TX_RADDR;
              end
            end
          end
          ST_TX_ADDR, ST_TX_REG, ST_TX_RADDR, ST_TX_DATA: begin
            held_sda_next = tx_bit;
            if (line_phase == 2'd0) begin
              held_scl_next   = 1'b0;
              line_phase_next = 2'd1;
            end else begin
              held_scl_next    = 1'b1;
              line_phase_next  = 2'd0;
              shift_byte_next  = {shift_byte[BYTE_BITS-2:0], 1'b0};
              bit_counter_next = bc_inc;
              if (bc_inc >= 4'(BYTE_BITS)) begin
                bit_counter_next = 4'd0;
                unique case (state)
                  ST_TX_ADDR:  state_next = ST_ACK_ADDR;
                  ST_TX_REG:   state_next = ST_ACK_REG;
                  ST_TX_RADDR: state_next = ST_ACK_RADDR;
                  default:     state_next = ST_ACK_DATA;
                endcase
              end
            end
          end
          ST_ACK_ADDR, ST_ACK_REG, ST_ACK_RADDR, ST_ACK_DATA: begin
            held_sda_next = 1'b1;
            if (line_phase == 2'd0) begin
              held_scl_next   = 1'b0;
              line_phase_next = 2'd1;
            end else begin
              held_scl_next   = 1'b1;
              line_phase_next = 2'd0;
              priority if (item.sda_in) begin
                // slave NACK: abort with STOP
                nack_latch_next = 1'b1;
                state_next      = ST_STOP;
              end else if (state == ST_ACK_ADDR) begin
                shift_byte_next  = saved_register;
                bit_counter_next = 4'd0;
                state_next       = ST_TX_REG;
              end else if (state == ST_ACK_REG && read_mode) begin
                state_next = ST_RESTART;
              end else if (state == ST_ACK_RADDR) begin
                shift_byte_next  = 8'd0;
                bit_counter_next = 4'd0;
                state_next       = (bytes_left != 8'd0) ? ST_RX : ST_STOP;
              end else begin
                state_next = (bytes_left != 8'd0) ? ST_WAIT_DATA : ST_STOP;
              end
            end
          end
          ST_WAIT_DATA: begin
            held_scl_next = 1'b0;
            held_sda_next = 1'b1;
          end
          ST_RX: begin
            held_sda_next = 1'b1;
            if (line_phase == 2'd0) begin
              held_scl_next   = 1'b0;
              line_phase_next = 2'd1;
            end else begin
              held_scl_next    = 1'b1;
              line_phase_next  = 2'd0;
              shift_byte_next  = rx_shift;
              bit_counter_next = bc_inc;
              if (bc_inc >= 4'(BYTE_BITS)) begin
                bit_counter_next = 4'd0;
                rv               = 1'b1;
                rb               = rx_shift;
                if (bytes_left != 8'd0) begin
                  bytes_left_next = bytes_left - 8'd1;
                end
                state_next = ST_MACK;
              end
            end
          end
          ST_MACK: begin
            // NACK the last byte, ACK the rest
            held_sda_next = mack_bit;
            if (line_phase == 2'd0) begin
              held_scl_next   = 1'b0;
              line_phase_next = 2'd1;
            end else begin
              held_scl_next   = 1'b1;
              line_phase_next = 2'd0;
              shift_byte_next = 8'd0;
              state_next      = mack_bit ? ST_STOP : ST_RX;
            end
          end
          ST_STOP: begin
            unique case (line_phase)
              2'd0: begin
                held_scl_next   = 1'b0;
                held_sda_next   = 1'b0;
                line_phase_next = 2'd1;
              end
              2'd1: begin
                held_scl_next   = 1'b1;
                held_sda_next   = 1'b0;
                line_phase_next = 2'd2;
              end
              default: begin
                held_scl_next   = 1'b1;
                held_sda_next   = 1'b1;
                line_phase_next = 2'd0;
                dn              = 1'b1;
                state_next      = ST_IDLE;
              end
            endcase
          end
          default: begin
            held_scl_next   = 1'b1;
            held_sda_next   = 1'b1;
            line_phase_next = 2'd0;
            state_next      = ST_IDLE;
          end
        endcase
      end
      FUNC_WRITE, FUNC_READ: begin
        if (state == ST_IDLE) begin
          saved_slave_next    = item.slave_addr;
          saved_register_next = item.reg_addr;
          bytes_left_next     = item.byte_count;
          read_mode_next      = (item.func == FUNC_READ);
          line_phase_next     = 2'd0;
          bit_counter_next    = 4'd0;
          shift_byte_next     = 8'd0;
          nack_latch_next     = 1'b0;
          state_next          = ST_START;
        end
      end
      default: begin
        if (state == ST_WAIT_DATA) begin
          shift_byte_next = item.write_byte;
          if (bytes_left != 8'd0) begin
            bytes_left_next = bytes_left - 8'd1;
          end
          bit_counter_next = 4'd0;
          line_phase_next  = 2'd0;
          state_next       = ST_TX_DATA;
        end
      end
    endcase
  end

  always_comb begin
    result.scl        = held_scl_next;
    result.sda_out    = held_sda_next;
    result.read_byte  = rb;
    result.read_valid = rv;
    result.need_byte  = (state_next == ST_WAIT_DATA);
    result.busy_res   = (state_next != ST_IDLE);
    result.nack_flag  = nack_latch_next;
    result.done_res   = dn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      line_phase     <= 2'd0;
      bit_counter    <= 4'd0;
      shift_byte     <= 8'd0;
      bytes_left     <= 8'd0;
      saved_slave    <= 8'd0;
      saved_register <= 8'd0;
      read_mode      <= 1'b0;
      held_scl       <= 1'b1;
      held_sda       <= 1'b1;
      nack_latch     <= 1'b0;
    end else if (en) begin
      state          <= state_next;
      line_phase     <= line_phase_next;
      bit_counter    <= bit_counter_next;
      shift_byte     <= shift_byte_next;
      bytes_left     <= bytes_left_next;
      saved_slave    <= saved_slave_next;
      saved_register <= saved_register_next;
      read_mode      <= read_mode_next;
      held_scl       <= held_scl_next;
      held_sda       <= held_sda_next;
      nack_latch     <= nack_latch_next;
    end
  end

endmodule

// File: hdl/i2c_master_register_transfer_unit.sv
// Top level of the I2C register transfer master: input register, bus
// sequencer and result register. Depends on i2cm_pkg and i2cm_core.
//
// Usage: every item transaction carries a command. func TICK advances the
// bus by one line phase (sda_in is the level sampled for that phase);
// WRITE and READ start a register-addressed transfer when the block is
// idle; SUPPLY hands over the next write data byte while need_byte is set.
// Each item yields exactly one result transaction with the line levels
// to drive (scl, sda_out), a received byte with read_valid, and the
// need_byte, busy_res, nack_flag and done_res status bits.
// Path: an accepted item waits in the input register, then the sequencer
// step loads its result into the result register. Throughput: one item per
// clock while result_ready is high; the sequencer step is a single pass of
// next-state logic.
// Reset: the bus is released (scl and sda high), the sequencer is idle,
// both registers are empty.
// Stall: while result_ready is low the result register holds its
// transaction; the input register still takes one more item, after which
// item_ready drops until the result is taken.
module i2c_master_register_transfer_unit
  import i2cm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  item_t   item_q;
  logic    item_q_valid;
  logic    step;
  result_t step_result;

  // Advance the sequencer when an item is held and the result slot frees.
  assign step       = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || step;

  i2cm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (step),
    .item   (item_q),
    .result (step_result)
  );

  // Input register: control reset, payload free-running on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Result register: load on each step, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= step_result;
    end
  end

endmodule
